// ===== rtl/assert_macros.svh =====
// assertion macros shared by the decoder rtl
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// condition that must hold at every clock edge outside reset
`define CGD_ASSERT(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("assertion failed");

// implication property, overlapping or not as written by the caller
`define CGD_ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("assertion failed");

`else

`define CGD_ASSERT(lbl, clk, rst_n, cond)
`define CGD_ASSERT_PROP(lbl, clk, rst_n, prop)

`endif

`endif

// ===== rtl/cgd_pkg.sv =====
// shared types and constants of the ctc greedy decoder
// no dependencies; imported by every rtl module of the block
`timescale 1ns / 1ps
`default_nettype none

package cgd_pkg;

    localparam int DEF_MAX_CLASSES = 128;
    localparam int DEF_MAX_STEPS   = 1024;

    localparam int PROB_W     = 16;
    localparam int CLASS_W    = 7;
    localparam int COUNT_W    = 11;
    localparam int DICT_W     = 8;
    localparam int FIFO_DEPTH = 4;

    localparam logic [DICT_W-1:0] DICT_RESET = 8'd128;

    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVGO,
        ST_DIV,
        ST_SUM
    } back_state_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } fifo_stat_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

// ===== rtl/cgd_front.sv =====
// front end: per-step argmax over the incoming class probabilities
// depends on cgd_pkg; pushes one step record into cgd_fifo per step
`timescale 1ns / 1ps
`default_nettype none

module cgd_front
    import cgd_pkg::*;
#(
    parameter int MAX_CLASSES = DEF_MAX_CLASSES,
    parameter int IDX_W = $clog2(MAX_CLASSES),
    parameter int REC_W = IDX_W + PROB_W + 1
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              accept,
    input  wire logic [PROB_W-1:0] prob,
    input  wire logic              last_class,
    input  wire logic              last_step,
    output logic                   push,
    output logic [REC_W-1:0]       rec
);

    localparam int POS_W = $clog2(MAX_CLASSES + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_CLASSES);

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [PROB_W-1:0] bv_reg, bv_next;
    logic [IDX_W-1:0]  bi_reg, bi_next;

    always_comb begin
        pos_next = pos_reg;
        bv_next  = bv_reg;
        bi_next  = bi_reg;
        push     = 1'b0;
        if (accept) begin
            if (pos_reg == '0) begin
                bv_next = prob;
                bi_next = '0;
            end else if (pos_reg < POS_MAX && prob > bv_reg) begin
                // strict compare keeps the first maximum on a tie
                bv_next = prob;
                bi_next = pos_reg[IDX_W-1:0];
            end
            if (pos_reg < POS_MAX) begin
                pos_next = pos_reg + POS_W'(1);
            end
            if (last_class) begin
                push     = 1'b1;
                pos_next = '0;
            end
        end
    end

    assign rec = {last_step, bv_next, bi_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            bv_reg  <= '0;
            bi_reg  <= '0;
        end else begin
            pos_reg <= pos_next;
            bv_reg  <= bv_next;
            bi_reg  <= bi_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cgd_fifo.sv =====
// small register queue of step records between front and back end
// depends on cgd_pkg for the status struct
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module cgd_fifo
    import cgd_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = FIFO_DEPTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rd_data,
    output fifo_stat_t            stat
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW:0]      wr_ptr_reg, wr_ptr_next;
    logic [AW:0]      rd_ptr_reg, rd_ptr_next;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + (AW+1)'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + (AW+1)'(1) : rd_ptr_reg;
    end

    assign stat.full      = (wr_ptr_reg[AW] != rd_ptr_reg[AW]) &&
                            (wr_ptr_reg[AW-1:0] == rd_ptr_reg[AW-1:0]);
    assign stat.not_empty = (wr_ptr_reg != rd_ptr_reg);
    assign rd_data        = mem_reg[rd_ptr_reg[AW-1:0]];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg[AW-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // the front end is held off by full, the back end only pops queued records
    `CGD_ASSERT(a_no_overflow, aclk, aresetn, !(push && stat.full && !pop))
    `CGD_ASSERT(a_no_underflow, aclk, aresetn, !(pop && !stat.not_empty))

endmodule

`default_nettype wire

// ===== rtl/cgd_div.sv =====
// restoring divider, one quotient bit per cycle, for the mean confidence
// depends on cgd_pkg for the status struct
`timescale 1ns / 1ps
`default_nettype none

module cgd_div
    import cgd_pkg::*;
#(
    parameter int NUM_W = 27,
    parameter int DEN_W = 11
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] dividend,
    input  wire logic [DEN_W-1:0] divisor,
    output logic [NUM_W-1:0]      quotient,
    output div_stat_t             stat
);

    localparam int IT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [IT_W-1:0]  it_reg, it_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        it_next   = it_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next = dividend;
            rem_next = '0;
            den_next = divisor;
            it_next  = IT_W'(NUM_W);
        end else if (it_reg != '0) begin
            quo_next = {quo_reg[NUM_W-2:0], ge};
            rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            it_next  = it_reg - IT_W'(1);
            if (it_reg == IT_W'(1)) begin
                done_next = 1'b1;
            end
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = (it_reg != '0);
    assign stat.done = done_reg;

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            it_reg   <= '0;
            done_reg <= 1'b0;
        end else begin
            it_reg   <= it_next;
            done_reg <= done_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cgd_back.sv =====
// back end: emission decision, sequence accounting and output register
// depends on cgd_pkg; reads step records from cgd_fifo, drives cgd_div
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module cgd_back
    import cgd_pkg::*;
#(
    parameter int MAX_CLASSES = DEF_MAX_CLASSES,
    parameter int MAX_STEPS = DEF_MAX_STEPS,
    parameter int IDX_W = $clog2(MAX_CLASSES),
    parameter int REC_W = IDX_W + PROB_W + 1,
    parameter int CNT_W = $clog2(MAX_STEPS + 1),
    parameter int SUM_W = CNT_W + PROB_W
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [DICT_W-1:0] dict_size,
    input  wire logic [REC_W-1:0]  rec,
    input  wire fifo_stat_t        fifo_stat,
    output logic                   pop,
    output logic                   div_start,
    output logic [SUM_W-1:0]       div_num,
    output logic [CNT_W-1:0]       div_den,
    input  wire logic [SUM_W-1:0]  div_quo,
    input  wire div_stat_t         div_stat,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [55:0]            m_tdata,
    output logic                   m_tuser,
    output logic                   m_tlast
);

    localparam int CMP_W = (IDX_W > DICT_W) ? IDX_W : DICT_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_STEPS);

    back_state_t state_reg, state_next;

    logic [IDX_W-1:0]   prev_idx_reg, prev_idx_next;
    logic               prev_none_reg, prev_none_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [PROB_W-1:0]  avg_reg, avg_next;

    logic               m_valid_reg, m_valid_next;
    logic               out_kind_reg, out_kind_next;
    logic [CLASS_W-1:0] out_idx_reg, out_idx_next;
    logic [PROB_W-1:0]  out_conf_reg, out_conf_next;
    logic [PROB_W-1:0]  out_avg_reg, out_avg_next;
    logic [COUNT_W-1:0] out_cnt_reg, out_cnt_next;

    logic [IDX_W-1:0]  rec_idx;
    logic [PROB_W-1:0] rec_value;
    logic              rec_last;
    logic              out_free;
    logic              emit;

    assign {rec_last, rec_value, rec_idx} = rec;
    assign out_free = !m_valid_reg || m_tready;

    // non-blank, not a repeat of the previous step, and inside the dictionary
    assign emit = (rec_idx != '0) &&
                  (prev_none_reg || rec_idx != prev_idx_reg) &&
                  (CMP_W'(rec_idx) < CMP_W'(dict_size));

    assign div_num = sum_reg;
    assign div_den = cnt_reg;

    always_comb begin
        state_next     = state_reg;
        prev_idx_next  = prev_idx_reg;
        prev_none_next = prev_none_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        avg_next       = avg_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        out_kind_next  = out_kind_reg;
        out_idx_next   = out_idx_reg;
        out_conf_next  = out_conf_reg;
        out_avg_next   = out_avg_reg;
        out_cnt_next   = out_cnt_reg;
        pop            = 1'b0;
        div_start      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (fifo_stat.not_empty && out_free) begin
                    pop            = 1'b1;
                    prev_idx_next  = rec_idx;
                    prev_none_next = 1'b0;
                    if (emit) begin
                        m_valid_next  = 1'b1;
                        out_kind_next = KIND_CHAR;
                        out_idx_next  = CLASS_W'(rec_idx);
                        out_conf_next = rec_value;
                        out_avg_next  = '0;
                        out_cnt_next  = '0;
                        if (cnt_reg < CNT_MAX) begin
                            sum_next = sum_reg + SUM_W'(rec_value);
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                    end
                    if (rec_last) begin
                        state_next = ST_DIVGO;
                    end
                end
            end
            ST_DIVGO: begin
                if (cnt_reg == '0) begin
                    avg_next   = '0;
                    state_next = ST_SUM;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    avg_next   = div_quo[PROB_W-1:0];
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    out_kind_next  = KIND_SUMMARY;
                    out_idx_next   = '0;
                    out_conf_next  = '0;
                    out_avg_next   = avg_reg;
                    out_cnt_next   = COUNT_W'(cnt_reg);
                    sum_next       = '0;
                    cnt_next       = '0;
                    prev_idx_next  = '0;
                    prev_none_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            prev_idx_reg  <= '0;
            prev_none_reg <= 1'b1;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            prev_idx_reg  <= prev_idx_next;
            prev_none_reg <= prev_none_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        avg_reg      <= avg_next;
        out_kind_reg <= out_kind_next;
        out_idx_reg  <= out_idx_next;
        out_conf_reg <= out_conf_next;
        out_avg_reg  <= out_avg_next;
        out_cnt_reg  <= out_cnt_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = (out_kind_reg == KIND_SUMMARY);
    assign m_tdata  = {6'd0, out_cnt_reg, out_avg_reg, out_conf_reg, out_idx_reg};

    // a summary is valid on the output in the cycle after it is loaded
    `CGD_ASSERT_PROP(a_sum_loaded, aclk, aresetn,
        (state_reg == ST_SUM && out_free) |=> (m_tvalid && m_tuser == KIND_SUMMARY))
    // the divider only answers while the back end waits for it
    `CGD_ASSERT_PROP(a_div_done_in_div, aclk, aresetn,
        div_stat.done |-> (state_reg == ST_DIV))
    // no queued record is consumed while a sequence summary is still pending
    `CGD_ASSERT_PROP(a_no_pop_busy, aclk, aresetn,
        pop |-> (state_reg == ST_IDLE && !div_stat.busy))

endmodule

`default_nettype wire

// ===== rtl/ctc_greedy_decoder_unit.sv =====
// top level of the ctc greedy (best path) decoder
// depends on cgd_pkg, cgd_front, cgd_fifo, cgd_div and cgd_back
`timescale 1ns / 1ps
`default_nettype none

// usage
//   s_ channel: one class probability per transaction, class by class within a
//   time step; s_tlast closes a step, s_tuser marks the final step of a sequence
//   m_ channel: a character transaction (m_tuser 0) for each decoded class and
//   one summary transaction (m_tuser 1, m_tlast 1) at the end of each sequence
//   cfg_ channel: writes dict_size, only while the block is idle
// timing
//   the input side takes one transaction per cycle; a step record goes into a
//   four-deep queue, and s_tready drops only while that queue is full
//   a character result passes from the closing item through the step queue and then the output register
//   the summary needs a restoring divide of one bit per cycle over the
//   confidence sum (MAX_STEPS count width plus 16 bits, 27 bits at the
//   defaults), then loads the output register; with no characters the divide is skipped
//   steps that close while the back end divides wait in the queue
// reset and stall
//   aresetn clears all sequence state and sets dict_size to 128
//   a stalled m_tready holds the output register; the queue keeps taking steps
//   until it fills, then back pressure reaches s_tready

module ctc_greedy_decoder_unit
    import cgd_pkg::*;
#(
    parameter int MAX_CLASSES = DEF_MAX_CLASSES,
    parameter int MAX_STEPS   = DEF_MAX_STEPS
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // configuration write: dict_size
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [DICT_W-1:0] cfg_data,
    // input stream
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [15:0]       s_tdata,  // [15:0] prob
    input  wire logic              s_tlast,  // last_class
    input  wire logic              s_tuser,  // [0] last_step
    // result stream
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [55:0]            m_tdata,  // [6:0] class_index, [22:7] char_confidence,
                                             // [38:23] avg_confidence, [49:39] char_count
    output logic                   m_tuser,  // [0] kind
    output logic                   m_tlast   // last
);

    localparam int IDX_W = $clog2(MAX_CLASSES);
    localparam int REC_W = IDX_W + PROB_W + 1;
    localparam int CNT_W = $clog2(MAX_STEPS + 1);
    localparam int SUM_W = CNT_W + PROB_W;

    logic [DICT_W-1:0] dict_reg, dict_next;

    logic              s_accept;
    logic              push;
    logic              pop;
    logic [REC_W-1:0]  rec_in;
    logic [REC_W-1:0]  rec_out;
    fifo_stat_t        fifo_stat;

    logic              div_start;
    logic [SUM_W-1:0]  div_num;
    logic [CNT_W-1:0]  div_den;
    logic [SUM_W-1:0]  div_quo;
    div_stat_t         div_stat;

    // configuration is always taken
    assign cfg_ready = 1'b1;
    assign dict_next = (cfg_valid && cfg_ready) ? cfg_data : dict_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dict_reg <= DICT_RESET;
        end else begin
            dict_reg <= dict_next;
        end
    end

    // the front end stalls whenever the step queue is full, not only on a step's closing item
    assign s_tready = !fifo_stat.full;
    assign s_accept = s_tvalid && s_tready;

    cgd_front #(
        .MAX_CLASSES (MAX_CLASSES),
        .IDX_W       (IDX_W),
        .REC_W       (REC_W)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (s_accept),
        .prob       (s_tdata[PROB_W-1:0]),
        .last_class (s_tlast),
        .last_step  (s_tuser),
        .push       (push),
        .rec        (rec_in)
    );

    cgd_fifo #(
        .WIDTH (REC_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_data (rec_in),
        .pop     (pop),
        .rd_data (rec_out),
        .stat    (fifo_stat)
    );

    cgd_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    cgd_back #(
        .MAX_CLASSES (MAX_CLASSES),
        .MAX_STEPS   (MAX_STEPS),
        .IDX_W       (IDX_W),
        .REC_W       (REC_W),
        .CNT_W       (CNT_W),
        .SUM_W       (SUM_W)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .dict_size (dict_reg),
        .rec       (rec_out),
        .fifo_stat (fifo_stat),
        .pop       (pop),
        .div_start (div_start),
        .div_num   (div_num),
        .div_den   (div_den),
        .div_quo   (div_quo),
        .div_stat  (div_stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

// ===== verif/tb_ctc_greedy_decoder_unit.sv =====
// self-checking testbench for ctc_greedy_decoder_unit: a directed stimulus table, then
// random sequences checked against an in-bench best-path decoder; depends on cgd_pkg and rtl
`timescale 1ns / 1ps
`default_nettype none

module tb_ctc_greedy_decoder_unit;
    import cgd_pkg::*;

    localparam int MAX_CLASSES  = DEF_MAX_CLASSES;
    localparam int MAX_CHARS    = DEF_MAX_STEPS;
    localparam int HOLD_OFF     = 64;        // covers the summary divide and pipeline
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int MAX_STEP_LEN = 140;       // 12 classes past MAX_CLASSES

    // one result transaction, field by field
    typedef struct packed {
        logic               kind;
        logic [CLASS_W-1:0] class_index;
        logic [PROB_W-1:0]  char_conf;
        logic [PROB_W-1:0]  avg_conf;
        logic [COUNT_W-1:0] char_count;
        logic               last;
    } decoded_t;

    // one row of the directed table; n_typed < 0 leaves the results to the decoder model
    typedef struct {
        logic [PROB_W-1:0] prob;
        logic              last_class;
        logic              last_step;
        int                reps;
        int                n_typed;
        decoded_t          typed0;
        decoded_t          typed1;
    } stim_row_t;

    typedef enum logic [1:0] {
        PROBS_TIED,
        PROBS_PEAKED,
        PROBS_RANDOM
    } prob_style_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [DICT_W-1:0] cfg_data  = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata   = '0;  // [15:0] prob
    logic              s_tlast   = 1'b0; // last_class
    logic              s_tuser   = 1'b0; // [0] last_step
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [55:0]       m_tdata;         // [6:0] class_index, [22:7] char_confidence,
                                        // [38:23] avg_confidence, [49:39] char_count
    logic              m_tuser;         // [0] kind
    logic              m_tlast;         // last

    ctc_greedy_decoder_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // decoder model state
    int          best_prob_m;
    int          best_class_m;
    int          class_pos_m;
    int          prev_class_m;
    bit          no_prev_m;
    longint      conf_sum_m;
    int          char_count_m;
    int          dict_size_m;

    // bookkeeping
    decoded_t    pending_results[$];
    stim_row_t   directed_rows[$];
    logic [15:0] step_probs[MAX_STEP_LEN];
    int          step_len;
    bit          steady_flow = 1'b0;   // no input gaps and no new result stalls while set
    int          errors = 0;
    int          items_sent = 0;
    int          sequences = 0;
    int          chars_seen = 0;
    int          summaries_seen = 0;
    int          dict_writes = 0;
    int          cycle_count = 0;

    function automatic decoded_t char_result(int idx, int conf);
        decoded_t r;
        r = '0;
        r.kind        = KIND_CHAR;
        r.class_index = idx[CLASS_W-1:0];
        r.char_conf   = conf[PROB_W-1:0];
        return r;
    endfunction

    function automatic decoded_t summary_result(int avg, int cnt);
        decoded_t r;
        r = '0;
        r.kind       = KIND_SUMMARY;
        r.avg_conf   = avg[PROB_W-1:0];
        r.char_count = cnt[COUNT_W-1:0];
        r.last       = 1'b1;
        return r;
    endfunction

    task automatic clear_sequence_model();
        prev_class_m = 0;
        no_prev_m    = 1'b1;
        conf_sum_m   = 0;
        char_count_m = 0;
    endtask

    // best-path decode of one class probability; up to two results per transaction
    task automatic predict_item(input logic [PROB_W-1:0] prob, input bit last_class,
                                input bit last_step, output int n,
                                output decoded_t r0, output decoded_t r1);
        decoded_t summ;
        longint   avg;
        n  = 0;
        r0 = '0;
        r1 = '0;
        // first class seeds the argmax, later ones must beat it strictly
        if (class_pos_m == 0) begin
            best_prob_m  = int'(prob);
            best_class_m = 0;
        end else if (class_pos_m < MAX_CLASSES && int'(prob) > best_prob_m) begin
            best_prob_m  = int'(prob);
            best_class_m = class_pos_m;
        end
        if (class_pos_m < MAX_CLASSES)
            class_pos_m++;
        if (last_class) begin
            class_pos_m = 0;
            // skip blank, repeated and out-of-dictionary classes
            if (best_class_m != 0 && (no_prev_m || best_class_m != prev_class_m)
                    && best_class_m < dict_size_m) begin
                r0 = char_result(best_class_m, best_prob_m);
                n  = 1;
                if (char_count_m < MAX_CHARS) begin
                    conf_sum_m += best_prob_m;
                    char_count_m++;
                end
            end
            prev_class_m = best_class_m;
            no_prev_m    = 1'b0;
            if (last_step) begin
                avg  = (char_count_m != 0) ? conf_sum_m / char_count_m : 0;
                summ = summary_result(int'(avg), char_count_m);
                if (n == 0)
                    r0 = summ;
                else
                    r1 = summ;
                n++;
                sequences++;
                clear_sequence_model();
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        errors++;
        $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // result checker, sampled at the rising edge
    always @(posedge aclk) begin : result_check
        decoded_t got;
        decoded_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind        = m_tuser;
            got.class_index = m_tdata[6:0];
            got.char_conf   = m_tdata[22:7];
            got.avg_conf    = m_tdata[38:23];
            got.char_count  = m_tdata[49:39];
            got.last        = m_tlast;
            if (got.kind == KIND_SUMMARY)
                summaries_seen++;
            else
                chars_seen++;
            if (m_tdata[55:50] != '0)
                report_mismatch($sformatf("padding bits 0x%h", m_tdata[55:50]));
            if (pending_results.size() == 0) begin
                report_mismatch("result transaction with none expected");
            end else begin
                want = pending_results.pop_front();
                compare_field("kind", int'(got.kind), int'(want.kind));
                compare_field("class_index", int'(got.class_index), int'(want.class_index));
                compare_field("char_confidence", int'(got.char_conf), int'(want.char_conf));
                compare_field("avg_confidence", int'(got.avg_conf), int'(want.avg_conf));
                compare_field("char_count", int'(got.char_count), int'(want.char_count));
                compare_field("last", int'(got.last), int'(want.last));
            end
        end
    end

    // result sink with random stalls, mostly short
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (!steady_flow && $urandom_range(0, 99) < 20)
                    stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 32)
                                                               : $urandom_range(1, 3);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 24);
    endfunction

    // drive one input transaction and, with use_model, book its expected results once accepted
    task automatic send_item(input logic [PROB_W-1:0] prob, input bit last_class,
                             input bit last_step, input bit use_model);
        int       gap;
        int       n;
        decoded_t r0;
        decoded_t r1;
        gap = pick_gap();
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= prob;
        s_tlast  <= last_class;
        s_tuser  <= last_step;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        predict_item(prob, last_class, last_step, n, r0, r1);
        if (use_model) begin
            if (n > 0)
                pending_results = {pending_results, r0};
            if (n > 1)
                pending_results = {pending_results, r1};
        end
    endtask

    // one time step from step_probs; last_step noise on the non-closing classes
    task automatic send_step(input bit seq_end);
        int i;
        bit closing;
        for (i = 0; i < step_len; i++) begin
            closing = (i == step_len - 1);
            send_item(step_probs[i], closing,
                      closing ? seq_end : ($urandom_range(0, 3) == 0), 1'b1);
        end
    endtask

    task automatic make_step();
        int          r;
        int          peak;
        int          i;
        int          sel;
        prob_style_t style;
        r = $urandom_range(0, 99);
        if (r < 5)
            step_len = 1;
        else if (r < 88)
            step_len = $urandom_range(2, 12);
        else if (r < 98)
            step_len = $urandom_range(13, 40);
        else
            step_len = $urandom_range(120, MAX_STEP_LEN);
        sel   = $urandom_range(0, 3);
        style = (sel > 2) ? PROBS_RANDOM : prob_style_t'(sel);
        peak  = $urandom_range(0, step_len - 1);
        for (i = 0; i < step_len; i++) begin
            case (style)
                PROBS_TIED: begin
                    sel = $urandom_range(0, 2);
                    step_probs[i] = (sel == 0) ? 16'h0000 : (sel == 1) ? 16'h8000 : 16'hFFFF;
                end
                PROBS_PEAKED: begin
                    step_probs[i] = (i == peak) ? 16'($urandom_range(16'h4000, 16'hFFFF))
                                                : 16'($urandom_range(0, 16'h3FFF));
                end
                default: begin
                    step_probs[i] = 16'($urandom_range(0, 16'hFFFF));
                end
            endcase
        end
    endtask

    // hold the sender until the block has delivered everything and gone quiet
    task automatic wait_for_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (HOLD_OFF) @(posedge aclk);
    endtask

    task automatic write_dict_size(input int value);
        wait_for_results();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value[DICT_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        dict_size_m = value & 8'hFF;
        dict_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // well-formed sequences with random content; one full drain halfway through
    task automatic run_random(input int budget);
        int start;
        int n_steps;
        int s;
        int r;
        bit paused;
        start  = items_sent;
        paused = 1'b0;
        while (items_sent - start < budget) begin
            steady_flow = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            n_steps = (r < 70) ? $urandom_range(1, 4)
                    : (r < 95) ? $urandom_range(5, 12) : $urandom_range(13, 30);
            for (s = 0; s < n_steps; s++) begin
                // sometimes repeat the previous step to hit the collapse rule
                if (step_len == 0 || $urandom_range(0, 6) != 0)
                    make_step();
                send_step(s == n_steps - 1);
            end
            if (!paused && items_sent - start >= budget / 2) begin
                wait_for_results();
                paused = 1'b1;
            end
        end
        steady_flow = 1'b0;
    endtask

    task automatic add_row(input logic [PROB_W-1:0] prob, input bit last_class,
                           input bit last_step, input int reps, input int n_typed,
                           input decoded_t typed0, input decoded_t typed1);
        stim_row_t row;
        row.prob       = prob;
        row.last_class = last_class;
        row.last_step  = last_step;
        row.reps       = reps;
        row.n_typed    = n_typed;
        row.typed0     = typed0;
        row.typed1     = typed1;
        directed_rows = {directed_rows, row};
    endtask

    // directed table, run right after reset with dict_size at its reset value
    task automatic build_table();
        // last_step without last_class is ignored
        add_row(16'h0000, 1'b0, 1'b1, 1, -1, '0, '0);
        add_row(16'hFFFF, 1'b1, 1'b0, 1, 1, char_result(1, 16'hFFFF), '0);
        // tie keeps class 1, a repeat of the last step, so only the summary
        add_row(16'h0005, 1'b0, 1'b0, 1, -1, '0, '0);
        add_row(16'hFFFF, 1'b0, 1'b0, 1, -1, '0, '0);
        add_row(16'hFFFF, 1'b1, 1'b1, 1, 1, summary_result(16'hFFFF, 1), '0);
        // sequence of one blank step, empty summary
        add_row(16'h7777, 1'b1, 1'b1, 1, 1, summary_result(0, 0), '0);
        add_row(16'h0010, 1'b0, 1'b0, 1, -1, '0, '0);
        add_row(16'h0020, 1'b0, 1'b1, 1, -1, '0, '0);
        add_row(16'h0030, 1'b1, 1'b0, 1, 1, char_result(2, 16'h0030), '0);
        // same step again collapses
        add_row(16'h0010, 1'b0, 1'b0, 1, -1, '0, '0);
        add_row(16'h0020, 1'b0, 1'b0, 1, -1, '0, '0);
        add_row(16'h0030, 1'b1, 1'b0, 1, 0, '0, '0);
        // blank step separates, so class 2 comes out again; mean 0x31 / 2 truncates
        add_row(16'hFFFF, 1'b1, 1'b0, 1, 0, '0, '0);
        add_row(16'h0000, 1'b0, 1'b0, 2, -1, '0, '0);
        add_row(16'h0001, 1'b1, 1'b1, 1, 2, char_result(2, 16'h0001),
                summary_result(16'h0018, 2));
        // class 127 wins, classes past the limit are ignored
        add_row(16'h0100, 1'b0, 1'b0, 127, -1, '0, '0);
        add_row(16'h0200, 1'b0, 1'b0, 1, -1, '0, '0);
        add_row(16'hFFFF, 1'b0, 1'b0, 3, -1, '0, '0);
        add_row(16'h0000, 1'b1, 1'b1, 1, 2, char_result(127, 16'h0200),
                summary_result(16'h0200, 1));
    endtask

    initial begin : stimulus
        int        i;
        int        rep;
        stim_row_t row;
        dict_size_m  = int'(DICT_RESET);
        best_prob_m  = 0;
        best_class_m = 0;
        class_pos_m  = 0;
        step_len     = 0;
        clear_sequence_model();
        build_table();
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < directed_rows.size(); i++) begin
            row = directed_rows[i];
            for (rep = 0; rep < row.reps; rep++)
                send_item(row.prob, row.last_class, row.last_step, row.n_typed < 0);
            if (row.n_typed > 0)
                pending_results = {pending_results, row.typed0};
            if (row.n_typed > 1)
                pending_results = {pending_results, row.typed1};
        end

        run_random(200);
        write_dict_size(0);        // every character dropped
        run_random(180);
        write_dict_size(2);        // only class 1 passes
        run_random(180);
        write_dict_size(255);
        run_random(180);
        write_dict_size($urandom_range(3, 24));
        run_random(200);
        write_dict_size(128);
        run_random(180);
        wait_for_results();

        $display("covered %0d input transactions in %0d sequences over %0d dict_size writes",
                 items_sent, sequences, dict_writes);
        $display("checked %0d character and %0d summary transactions, %0d mismatches",
                 chars_seen, summaries_seen, errors);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/cgd_pkg.sv
rtl/cgd_front.sv
rtl/cgd_fifo.sv
rtl/cgd_div.sv
rtl/cgd_back.sv
rtl/ctc_greedy_decoder_unit.sv
verif/tb_ctc_greedy_decoder_unit.sv
